FILE: rtl/rce_pkg.sv
package rce_pkg;

  // Frame size limits and the widths that follow from them.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WDIM_W     = COL_W + 1;
  localparam int HDIM_W     = ROW_W + 1;

  // Fixed field widths of the ports.
  localparam int PIX_W          = 8;
  localparam int FRAME_WIDTH_W  = 12;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 2;

  // Frame size after reset, clipped to the limits.
  localparam int RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int RESET_HEIGHT = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [WDIM_W-1:0] wdim_t;
  typedef logic [HDIM_W-1:0] hdim_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // Which results one source pixel gives, in output order.
  typedef struct packed {
    logic mag;
    logic right;
    logic bottom;
  } res_mask_t;

  // One classified pixel with its neighborhood.
  typedef struct packed {
    row_t      row;
    col_t      col;
    pix_t      px;
    pix_t      up;
    pix_t      ul;
    pix_t      left;
    res_mask_t mask;
  } job_t;

endpackage

FILE: rtl/roberts_cross_edge_magnitude.sv
// Roberts cross edge magnitude over a raster-order grayscale stream.
// Input channel: one 8-bit pixel per beat on in_valid_i/in_ready_o, in raster
// order for a frame whose width and height are set on the configuration
// channel (index 0 width, index 1 height); a write restarts the frame at its
// top left corner and must only be issued while the block is idle.
// Output channel: each beat carries out_row_o, out_column_o and magnitude_o.
// One pixel gives zero to three beats (edge magnitude for the pixel up and to
// the left, the right border pixel above, the bottom border pixel itself);
// last_o marks the final beat of one input pixel.
// Throughput: one pixel per cycle while out_ready_i is high and each pixel
// gives at most one beat; a pixel with two or three beats holds the output
// sequencer until its last beat is taken.
// Pixels are read from a line store with one read and one write port.
// Reset restores a 640 x 480 frame and clears the position counters; the line
// store holds no data until the first row has passed. When the receiver
// stalls, a four-entry job queue and the square-root pipeline fill first, then
// in_ready_o drops; no beat is lost.
module roberts_cross_edge_magnitude (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rce_pkg::PIX_W-1:0]       pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rce_pkg::ROW_W-1:0]       out_row_o,
  output logic [rce_pkg::COL_W-1:0]       out_column_o,
  output logic [rce_pkg::PIX_W-1:0]       magnitude_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rce_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rce_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic          fr_valid, q_full, q_valid, q_pop;
  rce_pkg::job_t fr_job, q_job;

  // Front: position tracking, line store and classification.
  rce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .job_valid_o (fr_valid),
    .job_ready_i (!q_full),
    .job_o       (fr_job)
  );

  // Job queue between the two halves.
  rce_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_valid),
    .push_data_i (fr_job),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_job)
  );

  // Back: magnitude pipeline and result sequencing.
  rce_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_ready_o  (q_pop),
    .job_i        (q_job),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o),
    .magnitude_o  (magnitude_o),
    .last_o       (last_o)
  );

endmodule

FILE: rtl/rce_front.sv
module rce_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rce_pkg::PIX_W-1:0]        pixel_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rce_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rce_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             job_valid_o,
  input  logic                             job_ready_i,
  output rce_pkg::job_t                    job_o
);

  rce_pkg::wdim_t w_q, w_d, w_new;
  rce_pkg::hdim_t h_q, h_d, h_new;
  rce_pkg::col_t  col_q, col_d;
  rce_pkg::row_t  row_q, row_d;
  logic           cfg_we, cfg_hit;
  logic           accept, last_col, last_row;

  logic              s1_valid_q, s1_valid_d;
  rce_pkg::row_t     s1_row_q;
  rce_pkg::col_t     s1_col_q;
  rce_pkg::pix_t     s1_px_q;
  rce_pkg::res_mask_t s1_mask_q;
  rce_pkg::pix_t     up_q;
  rce_pkg::pix_t     ul_q, left_q;
  logic              s1_done;

  rce_pkg::pix_t line_mem [rce_pkg::MAX_WIDTH];

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  // Clip written frame sizes: zero reads as one, large values as the limit.
  always_comb begin
    logic [rce_pkg::FRAME_WIDTH_W-1:0]  wraw;
    logic [rce_pkg::FRAME_HEIGHT_W-1:0] hraw;
    wraw = cfg_data_i[rce_pkg::FRAME_WIDTH_W-1:0];
    hraw = cfg_data_i[rce_pkg::FRAME_HEIGHT_W-1:0];
    if (wraw == '0) begin
      w_new = rce_pkg::wdim_t'(1);
    end else if (int'(wraw) > rce_pkg::MAX_WIDTH) begin
      w_new = rce_pkg::wdim_t'(rce_pkg::MAX_WIDTH);
    end else begin
      w_new = rce_pkg::wdim_t'(wraw);
    end
    if (hraw == '0) begin
      h_new = rce_pkg::hdim_t'(1);
    end else if (int'(hraw) > rce_pkg::MAX_HEIGHT) begin
      h_new = rce_pkg::hdim_t'(rce_pkg::MAX_HEIGHT);
    end else begin
      h_new = rce_pkg::hdim_t'(hraw);
    end
  end

  // Position bookkeeping.
  assign accept   = in_valid_i && in_ready_o;
  assign last_col = (rce_pkg::wdim_t'(col_q) == w_q - rce_pkg::wdim_t'(1));
  assign last_row = (rce_pkg::hdim_t'(row_q) == h_q - rce_pkg::hdim_t'(1));

  always_comb begin
    w_d     = w_q;
    h_d     = h_q;
    col_d   = col_q;
    row_d   = row_q;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index_i)
        rce_pkg::REG_FRAME_WIDTH: begin
          w_d     = w_new;
          cfg_hit = 1'b1;
        end
        rce_pkg::REG_FRAME_HEIGHT: begin
          h_d     = h_new;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : rce_pkg::row_t'(row_q + 1'b1);
      end else begin
        col_d = rce_pkg::col_t'(col_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= rce_pkg::wdim_t'(rce_pkg::RESET_WIDTH);
      h_q   <= rce_pkg::hdim_t'(rce_pkg::RESET_HEIGHT);
      col_q <= '0;
      row_q <= '0;
    end else begin
      w_q   <= w_d;
      h_q   <= h_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line store: the pixel above is read as the new one replaces it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_q            <= line_mem[col_q];
      line_mem[col_q] <= pixel_i;
    end
  end

  // Classification stage; pixels that give no result are dropped here.
  assign job_valid_o = s1_valid_q && (s1_mask_q != '0);
  assign s1_done     = s1_valid_q && ((s1_mask_q == '0) || job_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_done;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q         <= row_q;
      s1_col_q         <= col_q;
      s1_px_q          <= pixel_i;
      s1_mask_q.mag    <= (row_q != '0) && (col_q != '0);
      s1_mask_q.right  <= (row_q != '0) && last_col;
      s1_mask_q.bottom <= last_row;
    end
  end

  // Neighbors advance as each pixel leaves the classification stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q   <= '0;
      left_q <= '0;
    end else if (s1_done) begin
      ul_q   <= up_q;
      left_q <= s1_px_q;
    end
  end

  always_comb begin
    job_o.row  = s1_row_q;
    job_o.col  = s1_col_q;
    job_o.px   = s1_px_q;
    job_o.up   = up_q;
    job_o.ul   = ul_q;
    job_o.left = left_q;
    job_o.mask = s1_mask_q;
  end

endmodule

FILE: rtl/rce_fifo.sv
module rce_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rce_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          pop_valid_o,
  output rce_pkg::job_t pop_data_o
);

  rce_pkg::job_t                 entry_q [rce_pkg::QUEUE_DEPTH];
  logic [rce_pkg::QPTR_W-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [rce_pkg::QPTR_W:0]      cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o      = (cnt_q == (rce_pkg::QPTR_W + 1)'(rce_pkg::QUEUE_DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = entry_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == rce_pkg::QPTR_W'(rce_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == rce_pkg::QPTR_W'(rce_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/rce_back.sv
module rce_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  rce_pkg::job_t                 job_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rce_pkg::ROW_W-1:0]     out_row_o,
  output logic [rce_pkg::COL_W-1:0]     out_column_o,
  output logic [rce_pkg::PIX_W-1:0]     magnitude_o,
  output logic                          last_o
);

  typedef struct packed {
    logic [9:0] rem;
    logic [7:0] root;
  } root_t;

  // Four digits of the restoring square root, two radicand bits each.
  function automatic root_t root_step4(input logic [9:0] rem_in,
                                       input logic [7:0] root_in,
                                       input logic [7:0] pairs);
    logic [11:0] rem_v;
    logic [11:0] trial;
    logic [7:0]  root_v;
    root_t       res;
    rem_v  = {2'b00, rem_in};
    root_v = root_in;
    for (int k = 0; k < 4; k++) begin
      rem_v = {rem_v[9:0], pairs[7-2*k -: 2]};
      trial = {2'b00, root_v, 2'b01};
      if (rem_v >= trial) begin
        rem_v  = rem_v - trial;
        root_v = {root_v[6:0], 1'b1};
      end else begin
        root_v = {root_v[6:0], 1'b0};
      end
    end
    res.rem  = rem_v[9:0];
    res.root = root_v;
    return res;
  endfunction

  // Stage registers.
  logic          sq_v_q, rt1_v_q, rt2_v_q;
  rce_pkg::job_t sq_job_q, rt1_job_q, rt2_job_q;
  logic [15:0]   sq_a_q, sq_b_q;
  logic [9:0]    rt1_rem_q;
  logic [7:0]    rt1_root_q, rt1_low_q, rt2_mag_q;
  logic          rt1_sat_q;

  // Result sequencer registers.
  rce_pkg::res_mask_t em_mask_q, em_mask_d, em_cleared;
  rce_pkg::row_t      em_row_q;
  rce_pkg::col_t      em_col_q;
  rce_pkg::pix_t      em_px_q, em_up_q, em_mag_q;

  logic        out_fire, em_free;
  logic        rt2_mv, rt2_ready, rt1_mv, rt1_ready, sq_mv, sq_ready, pop;
  logic [7:0]  ad1, ad2;
  logic [16:0] sum;
  root_t       hi_res, lo_res;

  // Stage handshakes: a stage moves when the next one is free or moving.
  assign out_fire    = out_valid_o && out_ready_i;
  assign em_free     = (em_mask_q == '0) || (out_fire && (em_cleared == '0));
  assign rt2_mv      = rt2_v_q && em_free;
  assign rt2_ready   = !rt2_v_q || rt2_mv;
  assign rt1_mv      = rt1_v_q && rt2_ready;
  assign rt1_ready   = !rt1_v_q || rt1_mv;
  assign sq_mv       = sq_v_q && rt1_ready;
  assign sq_ready    = !sq_v_q || sq_mv;
  assign pop         = job_valid_i && sq_ready;
  assign job_ready_o = sq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q  <= 1'b0;
      rt1_v_q <= 1'b0;
      rt2_v_q <= 1'b0;
    end else begin
      if (pop) begin
        sq_v_q <= 1'b1;
      end else if (sq_mv) begin
        sq_v_q <= 1'b0;
      end
      if (sq_mv) begin
        rt1_v_q <= 1'b1;
      end else if (rt1_mv) begin
        rt1_v_q <= 1'b0;
      end
      if (rt1_mv) begin
        rt2_v_q <= 1'b1;
      end else if (rt2_mv) begin
        rt2_v_q <= 1'b0;
      end
    end
  end

  // Absolute diagonal differences, squared.
  assign ad1 = (job_i.ul >= job_i.px) ? job_i.ul - job_i.px : job_i.px - job_i.ul;
  assign ad2 = (job_i.left >= job_i.up) ? job_i.left - job_i.up : job_i.up - job_i.left;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sq_job_q <= job_i;
      sq_a_q   <= {8'd0, ad1} * {8'd0, ad1};
      sq_b_q   <= {8'd0, ad2} * {8'd0, ad2};
    end
  end

  // Sum of squares and the upper four root digits.
  assign sum    = {1'b0, sq_a_q} + {1'b0, sq_b_q};
  assign hi_res = root_step4(10'd0, 8'd0, sum[15:8]);

  always_ff @(posedge clk_i) begin
    if (sq_mv) begin
      rt1_job_q  <= sq_job_q;
      rt1_sat_q  <= sum[16];
      rt1_low_q  <= sum[7:0];
      rt1_rem_q  <= hi_res.rem;
      rt1_root_q <= hi_res.root;
    end
  end

  // Lower four root digits; a root of 256 or more saturates.
  assign lo_res = root_step4(rt1_rem_q, rt1_root_q, rt1_low_q);

  always_ff @(posedge clk_i) begin
    if (rt1_mv) begin
      rt2_job_q <= rt1_job_q;
      rt2_mag_q <= rt1_sat_q ? 8'hFF : lo_res.root;
    end
  end

  // Drop the result just delivered; order is magnitude, right, bottom.
  always_comb begin
    em_cleared = em_mask_q;
    priority if (em_mask_q.mag) begin
      em_cleared.mag = 1'b0;
    end else if (em_mask_q.right) begin
      em_cleared.right = 1'b0;
    end else begin
      em_cleared.bottom = 1'b0;
    end
  end

  always_comb begin
    em_mask_d = em_mask_q;
    if (rt2_mv) begin
      em_mask_d = rt2_job_q.mask;
    end else if (out_fire) begin
      em_mask_d = em_cleared;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_mask_q <= '0;
    end else begin
      em_mask_q <= em_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rt2_mv) begin
      em_row_q <= rt2_job_q.row;
      em_col_q <= rt2_job_q.col;
      em_px_q  <= rt2_job_q.px;
      em_up_q  <= rt2_job_q.up;
      em_mag_q <= rt2_mag_q;
    end
  end

  // Output beat for the first pending result.
  assign out_valid_o = (em_mask_q != '0);
  assign last_o      = (em_cleared == '0);

  always_comb begin
    out_row_o    = em_row_q;
    out_column_o = em_col_q;
    magnitude_o  = em_px_q;
    priority if (em_mask_q.mag) begin
      out_row_o    = em_row_q - 1'b1;
      out_column_o = em_col_q - 1'b1;
      magnitude_o  = em_mag_q;
    end else if (em_mask_q.right) begin
      out_row_o    = em_row_q - 1'b1;
      magnitude_o  = em_up_q;
    end else begin
      magnitude_o  = em_px_q;
    end
  end

endmodule
